// ===== sv/lph_pkg.sv =====
// Package for the linear-probing hash table: table geometry, command and
// status codes, and the packed transaction types of both channels.
// No dependencies.
package lph_pkg;

  // Table size; must be a power of two so the home slot is a bit-select.
  localparam int SLOTS = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = SLOT_W + 1;

  localparam int KEY_W = 31;
  localparam int CMD_W = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_FIELD_W = 4;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [KEY_W-1:0]  key_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    key_t             key;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [SLOT_FIELD_W-1:0] slot;
  } out_item_t;

endpackage

// ===== sv/lph_key_ram.sv =====
// Key store of the hash table: SLOTS x KEY_W synchronous RAM, one write
// port and one read port with registered read data. Depends on lph_pkg.
module lph_key_ram (
  input  logic               clk,
  input  logic               wr_en,
  input  lph_pkg::slot_idx_t wr_addr,
  input  lph_pkg::key_t      wr_data,
  input  lph_pkg::slot_idx_t rd_addr,
  output lph_pkg::key_t      rd_data
);
  import lph_pkg::*;

  key_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/linear_probe_hash_table.sv =====
// Linear-probing hash table: control, occupancy bits and result register.
// Depends on lph_pkg and lph_key_ram.
//
// Usage:
//   in_valid/in_ready/in_data carry one command transaction (insert, find,
//   delete) with a 31-bit key. out_valid/out_ready/out_data carry exactly one
//   result transaction per command: status and slot.
//   The home slot is the low SLOT_W bits of the key; probing walks forward
//   one slot per cycle and wraps.
// Processing:
//   Commands are processed one at a time. An insert probes 1..SLOTS
//   slots; find and delete probe up to SLOTS slots, and each key compare
//   waits on the registered key RAM read. When all SLOTS slots are probed
//   without a match, the last compare drains before the miss. The key RAM
//   has a single read port. An unused command answers "not found".
// Reset:
//   rst_n (synchronous, active low) empties the table at once; occupancy
//   lives in flops, the key RAM needs no clearing.
// Stalls:
//   A finished result sits in the output register until taken. The next
//   command is accepted meanwhile, and its result waits in the control FSM
//   until the output register frees up.
module linear_probe_hash_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lph_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lph_pkg::out_item_t out_data
);
  import lph_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  key_t                key_r, key_nxt;
  slot_idx_t           pos_r, pos_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  slot_idx_t           cmp_pos_r, cmp_pos_nxt;
  logic                stop_r, stop_nxt;
  logic [SLOTS-1:0]    occ_r, occ_nxt;
  out_item_t           res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic                ram_we;
  key_t                ram_rdata;
  logic                in_fire;

  lph_key_ram u_key_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (pos_r),
    .wr_data (key_r),
    .rd_addr (pos_r),
    .rd_data (ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign ram_we    = (state_r == S_INS) && !occ_r[pos_r];

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_pos_nxt   = cmp_pos_r;
    stop_nxt      = stop_r;
    occ_nxt       = occ_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt     = in_data.command;
          key_nxt     = in_data.key;
          pos_nxt     = in_data.key[SLOT_W-1:0];
          cnt_nxt     = '0;
          cmp_vld_nxt = 1'b0;
          stop_nxt    = 1'b0;
          case (in_data.command)
            CMD_INSERT: state_nxt = S_INS;
            CMD_FIND,
            CMD_DELETE: state_nxt = S_FIND;
            default: begin
              res_nxt   = '{status: ST_MISS, slot: '0};
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_INS: begin
        if (!occ_r[pos_r]) begin
          occ_nxt[pos_r] = 1'b1;
          res_nxt   = '{status: ST_OK, slot: SLOT_FIELD_W'(pos_r)};
          state_nxt = S_DONE;
        end else if (cnt_r == CNT_W'(SLOTS - 1)) begin
          res_nxt   = '{status: ST_FULL, slot: '0};
          state_nxt = S_DONE;
        end else begin
          pos_nxt = pos_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_FIND: begin
        // compare stage: key read for cmp_pos_r arrives this cycle
        if (cmp_vld_r && (ram_rdata == key_r)) begin
          if (cmd_r == CMD_DELETE) begin
            occ_nxt[cmp_pos_r] = 1'b0;
          end
          res_nxt   = '{status: ST_OK, slot: SLOT_FIELD_W'(cmp_pos_r)};
          state_nxt = S_DONE;
        end else if (stop_r) begin
          res_nxt   = '{status: ST_MISS, slot: '0};
          state_nxt = S_DONE;
        end else if ((cnt_r == CNT_W'(SLOTS)) || !occ_r[pos_r]) begin
          // probe chain ended; drain the compare in flight first
          cmp_vld_nxt = 1'b0;
          stop_nxt    = 1'b1;
        end else begin
          cmp_vld_nxt = 1'b1;
          cmp_pos_nxt = pos_r;
          pos_nxt     = pos_r + 1'b1;
          cnt_nxt     = cnt_r + 1'b1;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      stop_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      stop_r      <= stop_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    pos_r      <= pos_nxt;
    cmp_pos_r  <= cmp_pos_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Failed commands always report slot zero.
  a_slot_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status != ST_OK) |-> out_data_r.slot == '0)
    else $error("nonzero slot on failed command");

  // A key written by insert marks its slot occupied.
  a_insert_sets_occ: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> occ_r[$past(pos_r)])
    else $error("inserted slot not occupied");

  // The probe counter never runs past the table size.
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND) || (state_r == S_INS) |-> cnt_r <= CNT_W'(SLOTS))
    else $error("probe count exceeds table size");

  // A new result is loaded only from the done state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result loaded outside done state");

  // Occupancy is only modified while a command is active.
  a_occ_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) || (state_r == S_DONE) |=> $stable(occ_r))
    else $error("occupancy changed with no command active");

endmodule
